// ----- rtl/bfm_pkg.sv -----
package bfm_pkg;

  localparam int KSIZE_W = 4;
  localparam int DIM_W   = 11;
  localparam int PIX_W   = 8;
  localparam int DIVR_W  = 2 * KSIZE_W;

  localparam logic [KSIZE_W-1:0] KERNEL_SIZE_RESET  = 4'd5;
  localparam logic [DIM_W-1:0]   IMAGE_WIDTH_RESET  = 11'd512;
  localparam logic [DIM_W-1:0]   IMAGE_HEIGHT_RESET = 11'd512;

  typedef enum logic [1:0] {
    CFG_KERNEL_SIZE  = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2
  } cfg_index_t;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_DRAIN = 1'b1
  } kind_t;

  typedef struct packed {
    logic             kind;
    logic [PIX_W-1:0] pixel;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] mean_value;
    logic             last_in_frame;
  } out_word_t;

endpackage

// ----- rtl/bfm_line_mem.sv -----
module bfm_line_mem #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic [bfm_pkg::PIX_W-1:0] wdata,
  input  logic [AW-1:0]           raddr,
  output logic [bfm_pkg::PIX_W-1:0] rdata_r
);

  logic [bfm_pkg::PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

// ----- rtl/bfm_div.sv -----
// Restoring divider, one quotient bit per cycle, with the quotient
// saturated to eight bits.
module bfm_div #(
  parameter int SUM_W = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [SUM_W-1:0]              dividend,
  input  logic [bfm_pkg::DIVR_W-1:0]    divisor,
  output logic                          done_r,
  output logic [bfm_pkg::PIX_W-1:0]     quotient
);

  localparam int DW    = bfm_pkg::DIVR_W;
  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] quo_r, quo_nxt;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [DW-1:0]    dvs_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_nxt;
  logic [DW:0]      rem_sh;
  logic [DW:0]      trial;

  always_comb begin
    rem_sh   = {rem_r, quo_r[SUM_W-1]};
    trial    = rem_sh - {1'b0, dvs_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(SUM_W);
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = trial[DW-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DW-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign quotient = (quo_r > SUM_W'(255)) ? 8'hFF : quo_r[bfm_pkg::PIX_W-1:0];

endmodule

// ----- rtl/box_filter_mean_replicate.sv -----
// Streaming box filter: sum of the S by S window around every pixel of an
// 8-bit greyscale frame, divided by K*K, with the frame border replicated.
// Input words carry a kind bit and a pixel; pixels arrive in raster order and
// words after the frame, drains or pixels, flush the results that trail the
// input by half a kernel of rows and half a kernel of columns. Output words
// carry the mean and a flag on the last result of the frame. Both channels
// use valid/stall handshakes. An accepted word that yields no result leaves
// the block ready for the next word. A word that yields a result runs a
// window walk over S*S taps through the line memory, one read per cycle,
// where S = 2*(K/2)+1, then a bit-serial divide of a SUM_W-bit sum (SUM_W
// is 16 at the default parameters). The line memory has a single read port.
// A finished word waits in the output register; the next input word is
// taken while it waits, and a stalled receiver only blocks the block once a
// second result is ready behind it.
// Synchronous reset loads the register defaults (K = 5, 512 by 512) and
// clears all frame counters; the line memory is not cleared, as every read
// hits a pixel written earlier in the same frame. A configuration write
// restarts the frame.
module box_filter_mean_replicate #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_KERNEL = 15
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  bfm_pkg::in_word_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output bfm_pkg::out_word_t            out_data,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [bfm_pkg::DIM_W-1:0]     cfg_wdata
);

  localparam int RING_ROWS = 2 * (MAX_KERNEL / 2) + 2;
  localparam int SLOT_W    = $clog2(RING_ROWS);
  localparam int MEM_DEPTH = RING_ROWS * MAX_WIDTH;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW        = $clog2(MAX_WIDTH + 1);
  localparam int HW        = $clog2(MAX_HEIGHT + 1);
  localparam int CNT_W     = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int KEFF_MAX  = (MAX_KERNEL < 15) ? MAX_KERNEL : 15;
  localparam int SIDE_MAX  = 2 * (KEFF_MAX / 2) + 1;
  localparam int SUM_W     = $clog2(SIDE_MAX * SIDE_MAX * 255 + 1);
  localparam int KW        = bfm_pkg::KSIZE_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SUM   = 5'b00010,
    S_FLUSH = 5'b00100,
    S_DIV   = 5'b01000,
    S_HOLD  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [KW-1:0]               kernel_size_r, kernel_size_nxt;
  logic [bfm_pkg::DIM_W-1:0]   image_width_r, image_width_nxt;
  logic [bfm_pkg::DIM_W-1:0]   image_height_r, image_height_nxt;

  // Frame position counters.
  logic [COL_W-1:0]  in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [ROW_W-1:0]  in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [SLOT_W-1:0] in_slot_r, in_slot_nxt, out_slot_r, out_slot_nxt;
  logic [CNT_W-1:0]  pix_cnt_r, pix_cnt_nxt;
  logic              in_done_r, in_done_nxt;

  // Window walk.
  logic [KW-1:0]     dy_r, dy_nxt, dx_r, dx_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic [SUM_W-1:0]  acc_r, acc_nxt;
  logic              last_r, last_nxt;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  bfm_pkg::out_word_t  out_data_r, out_data_nxt;

  logic [WW-1:0]     eff_w;
  logic [HW-1:0]     eff_h;
  logic [KW-1:0]     eff_k;
  logic [KW-2:0]     half;
  logic [KW-1:0]     side_m1;
  logic [31:0]       lag;
  logic              in_acc, out_free;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [bfm_pkg::PIX_W-1:0] mem_rdata;
  logic              div_start, div_done;
  logic [bfm_pkg::PIX_W-1:0] div_q;
  logic [bfm_pkg::DIVR_W-1:0] divisor;
  logic              cfg_hit;

  // Effective geometry: zero acts as one, oversize saturates.
  always_comb begin
    if (image_width_r == '0) begin
      eff_w = WW'(1);
    end else if (32'(image_width_r) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(image_width_r);
    end
    if (image_height_r == '0) begin
      eff_h = HW'(1);
    end else if (32'(image_height_r) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(image_height_r);
    end
    if (kernel_size_r == '0) begin
      eff_k = KW'(1);
    end else if (32'(kernel_size_r) > MAX_KERNEL) begin
      eff_k = KW'(MAX_KERNEL);
    end else begin
      eff_k = kernel_size_r;
    end
  end

  assign half    = eff_k[KW-1:1];
  assign side_m1 = {half, 1'b0};
  assign divisor = bfm_pkg::DIVR_W'(eff_k) * bfm_pkg::DIVR_W'(eff_k);

  // Results trail the inputs by half rows plus half columns (capped at the row).
  assign lag = 32'(half) * 32'(eff_w)
             + ((32'(half) < 32'(eff_w) - 32'd1) ? 32'(half) : 32'(eff_w) - 32'd1);

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign mem_we    = in_acc && (in_data.kind == bfm_pkg::KIND_PIXEL) && !in_done_r;
  assign mem_waddr = AW'(32'(in_slot_r) * MAX_WIDTH + 32'(in_col_r));

  // Read address of the current window tap, with clamped coordinates and
  // the ring slot derived from the output row's slot.
  always_comb begin
    logic signed [31:0] r, rc, d, c, cc;
    r  = $signed(32'(out_row_r)) + $signed(32'(dy_r)) - $signed(32'(half));
    if (r < 0) begin
      rc = 0;
    end else if (r >= $signed(32'(eff_h))) begin
      rc = $signed(32'(eff_h)) - 1;
    end else begin
      rc = r;
    end
    d = $signed(32'(out_slot_r)) + rc - $signed(32'(out_row_r));
    if (d < 0) begin
      d = d + RING_ROWS;
    end else if (d >= RING_ROWS) begin
      d = d - RING_ROWS;
    end
    c = $signed(32'(out_col_r)) + $signed(32'(dx_r)) - $signed(32'(half));
    if (c < 0) begin
      cc = 0;
    end else if (c >= $signed(32'(eff_w))) begin
      cc = $signed(32'(eff_w)) - 1;
    end else begin
      cc = c;
    end
    mem_raddr = AW'(d * MAX_WIDTH + cc);
  end

  assign cfg_hit = cfg_we && ((cfg_index == bfm_pkg::CFG_KERNEL_SIZE) ||
                              (cfg_index == bfm_pkg::CFG_IMAGE_WIDTH) ||
                              (cfg_index == bfm_pkg::CFG_IMAGE_HEIGHT));

  always_comb begin
    state_nxt        = state_r;
    kernel_size_nxt  = kernel_size_r;
    image_width_nxt  = image_width_r;
    image_height_nxt = image_height_r;
    in_col_nxt       = in_col_r;
    in_row_nxt       = in_row_r;
    in_slot_nxt      = in_slot_r;
    out_col_nxt      = out_col_r;
    out_row_nxt      = out_row_r;
    out_slot_nxt     = out_slot_r;
    pix_cnt_nxt      = pix_cnt_r;
    in_done_nxt      = in_done_r;
    dy_nxt           = dy_r;
    dx_nxt           = dx_r;
    rd_pend_nxt      = 1'b0;
    acc_nxt          = acc_r + (rd_pend_r ? SUM_W'(mem_rdata) : SUM_W'(0));
    last_nxt         = last_r;
    div_start        = 1'b0;
    out_valid_nxt    = out_valid_r && out_stall;
    out_data_nxt     = out_data_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (mem_we) begin
            // Store the pixel and advance the input position.
            pix_cnt_nxt = pix_cnt_r + CNT_W'(1);
            if (32'(in_col_r) + 32'd1 >= 32'(eff_w)) begin
              in_col_nxt = '0;
              if (32'(in_row_r) + 32'd1 >= 32'(eff_h)) begin
                in_row_nxt  = '0;
                in_slot_nxt = '0;
                in_done_nxt = 1'b1;
              end else begin
                in_row_nxt  = in_row_r + ROW_W'(1);
                in_slot_nxt = (in_slot_r == SLOT_W'(RING_ROWS - 1)) ?
                              '0 : in_slot_r + SLOT_W'(1);
              end
            end else begin
              in_col_nxt = in_col_r + COL_W'(1);
            end
            if (32'(pix_cnt_r) + 32'd1 > lag) begin
              state_nxt = S_SUM;
            end
          end else if (in_done_r) begin
            state_nxt = S_SUM;
          end
          dy_nxt  = '0;
          dx_nxt  = '0;
          acc_nxt = '0;
        end
      end
      S_SUM: begin
        rd_pend_nxt = 1'b1;
        if (dx_r == side_m1) begin
          dx_nxt = '0;
          if (dy_r == side_m1) begin
            state_nxt = S_FLUSH;
          end else begin
            dy_nxt = dy_r + KW'(1);
          end
        end else begin
          dx_nxt = dx_r + KW'(1);
        end
      end
      S_FLUSH: begin
        // Last tap lands this cycle; start the divide and advance the
        // output position.
        div_start = 1'b0;
        state_nxt = S_DIV;
        last_nxt  = (32'(out_row_r) == 32'(eff_h) - 32'd1) &&
                    (32'(out_col_r) == 32'(eff_w) - 32'd1);
        if (last_nxt) begin
          out_col_nxt  = '0;
          out_row_nxt  = '0;
          out_slot_nxt = '0;
          in_col_nxt   = '0;
          in_row_nxt   = '0;
          in_slot_nxt  = '0;
          pix_cnt_nxt  = '0;
          in_done_nxt  = 1'b0;
        end else if (32'(out_col_r) + 32'd1 >= 32'(eff_w)) begin
          out_col_nxt  = '0;
          out_row_nxt  = out_row_r + ROW_W'(1);
          out_slot_nxt = (out_slot_r == SLOT_W'(RING_ROWS - 1)) ?
                         '0 : out_slot_r + SLOT_W'(1);
        end else begin
          out_col_nxt = out_col_r + COL_W'(1);
        end
        div_start = 1'b1;
      end
      S_DIV, S_HOLD: begin
        if (div_done) begin
          if (out_free) begin
            out_valid_nxt               = 1'b1;
            out_data_nxt.mean_value     = div_q;
            out_data_nxt.last_in_frame  = last_r;
            state_nxt                   = S_IDLE;
          end else begin
            state_nxt = S_HOLD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_hit) begin
      case (cfg_index)
        bfm_pkg::CFG_KERNEL_SIZE:  kernel_size_nxt  = cfg_wdata[KW-1:0];
        bfm_pkg::CFG_IMAGE_WIDTH:  image_width_nxt  = cfg_wdata;
        bfm_pkg::CFG_IMAGE_HEIGHT: image_height_nxt = cfg_wdata;
        default: begin
        end
      endcase
      in_col_nxt   = '0;
      in_row_nxt   = '0;
      in_slot_nxt  = '0;
      out_col_nxt  = '0;
      out_row_nxt  = '0;
      out_slot_nxt = '0;
      pix_cnt_nxt  = '0;
      in_done_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      kernel_size_r  <= bfm_pkg::KERNEL_SIZE_RESET;
      image_width_r  <= bfm_pkg::IMAGE_WIDTH_RESET;
      image_height_r <= bfm_pkg::IMAGE_HEIGHT_RESET;
      in_col_r       <= '0;
      in_row_r       <= '0;
      in_slot_r      <= '0;
      out_col_r      <= '0;
      out_row_r      <= '0;
      out_slot_r     <= '0;
      pix_cnt_r      <= '0;
      in_done_r      <= 1'b0;
      dy_r           <= '0;
      dx_r           <= '0;
      rd_pend_r      <= 1'b0;
      last_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      kernel_size_r  <= kernel_size_nxt;
      image_width_r  <= image_width_nxt;
      image_height_r <= image_height_nxt;
      in_col_r       <= in_col_nxt;
      in_row_r       <= in_row_nxt;
      in_slot_r      <= in_slot_nxt;
      out_col_r      <= out_col_nxt;
      out_row_r      <= out_row_nxt;
      out_slot_r     <= out_slot_nxt;
      pix_cnt_r      <= pix_cnt_nxt;
      in_done_r      <= in_done_nxt;
      dy_r           <= dy_nxt;
      dx_r           <= dx_nxt;
      rd_pend_r      <= rd_pend_nxt;
      last_r         <= last_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  bfm_line_mem #(
    .DEPTH (MEM_DEPTH),
    .AW    (AW)
  ) u_line_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (in_data.pixel),
    .raddr   (mem_raddr),
    .rdata_r (mem_rdata)
  );

  bfm_div #(
    .SUM_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_nxt),
    .divisor  (divisor),
    .done_r   (div_done),
    .quotient (div_q)
  );

  // A drain word before the frame is complete yields nothing.
  a_early_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.kind == bfm_pkg::KIND_DRAIN && !in_done_r && !cfg_hit)
      |=> state_r == S_IDLE)
    else $error("early drain started a window walk");

  // The final tap is always followed by the divide.
  a_flush_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FLUSH |=> state_r == S_DIV)
    else $error("window walk did not hand over to the divider");

  // A finished quotient with a free output register becomes an output word.
  a_load_out: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DIV || state_r == S_HOLD) && div_done && out_free) |=> out_valid_r)
    else $error("result was not loaded into the output register");

  // A register write restarts the frame.
  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> (pix_cnt_r == '0 && !in_done_r))
    else $error("register write did not restart the frame");

endmodule

// ----- tb/tb.sv -----
module tb;

  // Index 3 is not a register; a write there must be ignored.
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int RING_ROWS = 16;
  localparam int LINE_LEN = 1024;
  localparam int TARGET_WORDS = 1300;
  localparam int LONG_HOLD = 1500;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  bfm_pkg::in_word_t           in_data;
  logic                        out_valid;
  logic                        out_stall;
  bfm_pkg::out_word_t          out_data;
  logic                        cfg_we;
  logic [1:0]                  cfg_index;
  logic [bfm_pkg::DIM_W-1:0]   cfg_wdata;

  box_filter_mean_replicate dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Words waiting to be offered, and means the filter still owes us.
  bfm_pkg::in_word_t  word_queue[$];
  bfm_pkg::out_word_t mean_queue[$];

  // Our own copy of the filter state.
  logic [7:0]        pix_ring [0:RING_ROWS*LINE_LEN-1];
  int unsigned       row_in, col_in, row_out, col_out;
  bit                frame_full;
  logic [bfm_pkg::KSIZE_W-1:0] k_reg;
  logic [bfm_pkg::DIM_W-1:0]   w_reg, h_reg;

  int  errors = 0;
  int  means_checked = 0;
  int  words_made = 0;
  int  frames_run = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  send_hold = 0;
  bit  hold_go = 0;
  bit  hold_taken = 0;
  int  hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Effective geometry: zero acts as one, oversize values saturate.
  function automatic int unsigned frame_w();
    if (w_reg == 0) return 1;
    return (w_reg > LINE_LEN) ? LINE_LEN : w_reg;
  endfunction

  function automatic int unsigned frame_h();
    if (h_reg == 0) return 1;
    return (h_reg > 1024) ? 1024 : h_reg;
  endfunction

  function automatic int unsigned kern_k();
    if (k_reg == 0) return 1;
    return k_reg;
  endfunction

  // Number of results that trail the input: half a kernel of rows plus
  // half a kernel of columns, the latter capped by the row length.
  function automatic int unsigned trail_len();
    int unsigned w, half;
    w = frame_w();
    half = kern_k() / 2;
    return half * w + ((half < w - 1) ? half : w - 1);
  endfunction

  function automatic void restart_frame();
    row_in = 0; col_in = 0; row_out = 0; col_out = 0;
    frame_full = 0;
  endfunction

  function automatic int unsigned clamp_coord(int v, int unsigned lim);
    if (v < 0) return 0;
    if (v >= int'(lim)) return lim - 1;
    return v;
  endfunction

  // Window mean around the next output position, then step that position.
  function automatic void push_window_mean();
    int unsigned w, h, k, rr, cc, sum, mean;
    int half;
    bfm_pkg::out_word_t o;
    w = frame_w();
    h = frame_h();
    k = kern_k();
    half = k / 2;
    sum = 0;
    for (int dy = -half; dy <= half; dy++) begin
      rr = clamp_coord(int'(row_out) + dy, h) % RING_ROWS;
      for (int dx = -half; dx <= half; dx++) begin
        cc = clamp_coord(int'(col_out) + dx, w);
        sum += pix_ring[rr * LINE_LEN + cc];
      end
    end
    mean = sum / (k * k);
    if (mean > 255) mean = 255;
    o.mean_value = mean[7:0];
    o.last_in_frame = (row_out == h - 1) && (col_out == w - 1);
    mean_queue.insert(mean_queue.size(), o);
    if (o.last_in_frame) begin
      restart_frame();
    end else if (col_out + 1 >= w) begin
      col_out = 0;
      row_out++;
    end else begin
      col_out++;
    end
  endfunction

  // Apply one accepted word to the model state.
  function automatic void take_word(bfm_pkg::in_word_t wd);
    int unsigned w, h, received;
    w = frame_w();
    h = frame_h();
    // A drain before the frame is complete does nothing; any word after
    // the frame is complete flushes one result.
    if (wd.kind == bfm_pkg::KIND_DRAIN || frame_full) begin
      if (frame_full) push_window_mean();
      return;
    end
    pix_ring[(row_in % RING_ROWS) * LINE_LEN + col_in] = wd.pixel;
    if (col_in + 1 >= w) begin
      col_in = 0;
      if (row_in + 1 >= h) begin
        row_in = 0;
        frame_full = 1;
      end else begin
        row_in++;
      end
    end else begin
      col_in++;
    end
    received = frame_full ? w * h : row_in * w + col_in;
    if (received > trail_len()) push_window_mean();
  endfunction

  // Driver: a word is accepted when valid is high and stall is low. A new
  // word is loaded only once the current one has gone, so a stalled
  // payload never changes.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && !in_stall) take_word(in_data);
      if (!in_valid || !in_stall) begin
        if (word_queue.size() > 0 && !send_hold &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          in_data <= word_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every accepted result against the oldest expected
  // mean. It also owns the receiver stall, including the one long hold
  // that lets the filter back up into its input.
  always @(posedge clk) begin
    bfm_pkg::out_word_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (mean_queue.size() == 0) begin
          $display("%0t: unexpected result mean=%0d last=%0b", $time,
                   out_data.mean_value, out_data.last_in_frame);
          errors++;
        end else begin
          want = mean_queue.pop_front();
          means_checked++;
          if (out_data.mean_value !== want.mean_value) begin
            $display("%0t: mean expected %0d actual %0d", $time,
                     want.mean_value, out_data.mean_value);
            errors++;
          end
          if (out_data.last_in_frame !== want.last_in_frame) begin
            $display("%0t: last_in_frame expected %0b actual %0b", $time,
                     want.last_in_frame, out_data.last_in_frame);
            errors++;
          end
        end
      end
      if (hold_go && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_left <= LONG_HOLD;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
      out_stall <= (hold_left > 1) || ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // One register write; the model copy changes at the edge that drives the write.
  task automatic write_reg(logic [1:0] idx, logic [bfm_pkg::DIM_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      bfm_pkg::CFG_KERNEL_SIZE: begin
        k_reg = val[bfm_pkg::KSIZE_W-1:0];
        restart_frame();
      end
      bfm_pkg::CFG_IMAGE_WIDTH:  begin w_reg = val; restart_frame(); end
      bfm_pkg::CFG_IMAGE_HEIGHT: begin h_reg = val; restart_frame(); end
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every word has gone in and every mean has come out, then
  // allow for a word still at work inside the filter.
  task automatic wait_quiet();
    @(posedge clk);
    while (word_queue.size() > 0 || in_valid || mean_queue.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic add_word(bfm_pkg::kind_t kd, logic [7:0] px);
    bfm_pkg::in_word_t wd;
    wd.kind = kd;
    wd.pixel = px;
    word_queue.insert(word_queue.size(), wd);
    words_made++;
  endtask

  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One whole frame with random content. Stray drains fall inside the
  // frame; the flush uses both drain words and surplus pixels.
  task automatic queue_frame();
    int unsigned n, flush;
    n = frame_w() * frame_h();
    flush = trail_len();
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0)
        add_word(bfm_pkg::KIND_DRAIN, 8'($urandom_range(0, 255)));
      add_word(bfm_pkg::KIND_PIXEL, pick_pixel());
    end
    for (int unsigned i = 0; i < flush; i++)
      add_word($urandom_range(0, 3) == 0 ? bfm_pkg::KIND_PIXEL : bfm_pkg::KIND_DRAIN,
               8'($urandom_range(0, 255)));
    // A drain after the frame has finished is ignored.
    if ($urandom_range(0, 3) == 0)
      add_word(bfm_pkg::KIND_DRAIN, 8'($urandom_range(0, 255)));
    frames_run++;
  endtask

  initial begin
    int phase;
    cfg_we = 1'b0;
    cfg_index = bfm_pkg::CFG_KERNEL_SIZE;
    cfg_wdata = '0;
    k_reg = bfm_pkg::KERNEL_SIZE_RESET;
    w_reg = bfm_pkg::IMAGE_WIDTH_RESET;
    h_reg = bfm_pkg::IMAGE_HEIGHT_RESET;
    restart_frame();
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: kernel zero acts as one, width saturates to the line
    // length and a zero height acts as one; each pixel gives its own mean.
    write_reg(bfm_pkg::CFG_KERNEL_SIZE, 11'd0);
    write_reg(bfm_pkg::CFG_IMAGE_WIDTH, 11'h7FF);
    write_reg(bfm_pkg::CFG_IMAGE_HEIGHT, 11'd0);
    add_word(bfm_pkg::KIND_DRAIN, 8'hFF);
    add_word(bfm_pkg::KIND_PIXEL, 8'd0);
    add_word(bfm_pkg::KIND_PIXEL, 8'd255);
    add_word(bfm_pkg::KIND_PIXEL, 8'h55);
    add_word(bfm_pkg::KIND_PIXEL, 8'hAA);
    wait_quiet();

    // Largest kernel on a tiny frame: every window is mostly replicas.
    write_reg(bfm_pkg::CFG_KERNEL_SIZE, 11'd15);
    write_reg(bfm_pkg::CFG_IMAGE_WIDTH, 11'd3);
    write_reg(bfm_pkg::CFG_IMAGE_HEIGHT, 11'd2);
    write_reg(CFG_UNUSED, 11'h7FF);
    add_word(bfm_pkg::KIND_PIXEL, 8'd255);
    add_word(bfm_pkg::KIND_PIXEL, 8'd0);
    add_word(bfm_pkg::KIND_PIXEL, 8'd255);
    add_word(bfm_pkg::KIND_PIXEL, 8'd1);
    add_word(bfm_pkg::KIND_PIXEL, 8'd254);
    add_word(bfm_pkg::KIND_PIXEL, 8'd128);
    repeat (3) add_word(bfm_pkg::KIND_DRAIN, 8'd0);
    repeat (3) add_word(bfm_pkg::KIND_PIXEL, 8'd77);
    wait_quiet();

    // Even kernel: the window is one wider than the divisor suggests, so a
    // white frame saturates. The flush mixes drains and surplus pixels.
    write_reg(bfm_pkg::CFG_KERNEL_SIZE, 11'd4);
    write_reg(bfm_pkg::CFG_IMAGE_WIDTH, 11'd2);
    write_reg(bfm_pkg::CFG_IMAGE_HEIGHT, 11'd2);
    repeat (4) add_word(bfm_pkg::KIND_PIXEL, 8'd255);
    add_word(bfm_pkg::KIND_DRAIN, 8'd0);
    add_word(bfm_pkg::KIND_PIXEL, 8'd3);
    add_word(bfm_pkg::KIND_DRAIN, 8'd0);
    wait_quiet();

    // Random frames in three phases of handshake pressure.
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 46 : 0;
      recv_stall_pct = (phase == 0) ? 46 : (phase == 1) ? 9 : 0;
      while (words_made < TARGET_WORDS * (phase + 1) / 3) begin
        write_reg(bfm_pkg::CFG_KERNEL_SIZE, 11'(($urandom_range(0, 3) == 0) ?
                  $urandom_range(0, 15) : $urandom_range(1, 7)));
        if ($urandom_range(0, 9) == 0)
          write_reg(bfm_pkg::CFG_IMAGE_WIDTH, 11'($urandom_range(0, 48)));
        else
          write_reg(bfm_pkg::CFG_IMAGE_WIDTH, 11'($urandom_range(1, 12)));
        write_reg(bfm_pkg::CFG_IMAGE_HEIGHT, 11'($urandom_range(0, 6)));
        queue_frame();
        if (phase == 0 && !hold_taken) hold_go <= 1'b1;
        if (phase == 1 && frames_run % 4 == 0) begin
          // Stop offering with at most eight words left and let the filter empty completely.
          while (word_queue.size() > 8) @(posedge clk);
          send_hold <= 1'b1;
          @(posedge clk);
          while (in_valid || mean_queue.size() > 0) @(posedge clk);
          repeat (20) @(posedge clk);
          send_hold <= 1'b0;
        end
        wait_quiet();
      end
    end

    $display("tb: %0d words in %0d random frames plus directed cases, %0d means checked",
             words_made, frames_run, means_checked);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("tb: failure");
    $finish;
  end

endmodule
